// ----- sv/assert_macros.svh -----
// Assertion macros shared by the decoder RTL.
// Included by every module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define UDC_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("udc assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define UDC_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("udc assertion failed");

`endif

// ----- sv/udc_pkg.sv -----
// Types, constants and classing function for the UTF-8 decoder.
// Used by every module of the decoder; depends on nothing else.
package udc_pkg;

    localparam int UDC_QUEUE_DEPTH = 4;

    localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
    localparam logic [20:0] SURROGATE_LO   = 21'h00D800;
    localparam logic [20:0] SURROGATE_HI   = 21'h00DFFF;
    localparam logic [20:0] MIN_LEN2       = 21'h000080;
    localparam logic [20:0] MIN_LEN3       = 21'h000800;
    localparam logic [20:0] MIN_LEN4       = 21'h010000;

    localparam logic [1:0] CLASS_OTHER = 2'd0;
    localparam logic [1:0] CLASS_CJK   = 2'd1;
    localparam logic [1:0] CLASS_ALNUM = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_byte_item;

    typedef struct packed {
        logic        decoded_ok;
        logic [20:0] code_value;
        logic [1:0]  char_class;
        logic        last_of_run;
    } t_result;

    // Everything one input byte causes: some rejections, then at most one code point.
    typedef struct packed {
        logic [2:0]  reject_count;
        logic        point_ok;
        logic [20:0] point_value;
        logic [1:0]  point_class;
    } t_work;

    typedef struct packed {
        logic [20:0] value;
        logic [1:0]  cls;
    } t_classed;

    function automatic t_classed classify(input logic [20:0] v);
        t_classed c;
        c.value = v;
        c.cls   = CLASS_OTHER;
        if ((v >= 21'h03400 && v <= 21'h04DBF) || (v >= 21'h04E00 && v <= 21'h09FFF) ||
            (v >= 21'h0F900 && v <= 21'h0FAFF) || (v >= 21'h20000 && v <= 21'h2FA1F) ||
            (v >= 21'h30000 && v <= 21'h323AF)) begin
            c.cls = CLASS_CJK;
        end else if (v >= 21'h41 && v <= 21'h5A) begin
            c.value = v + 21'h20;
            c.cls   = CLASS_ALNUM;
        end else if ((v >= 21'h61 && v <= 21'h7A) || (v >= 21'h30 && v <= 21'h39)) begin
            c.cls = CLASS_ALNUM;
        end
        return c;
    endfunction

endpackage

// ----- sv/udc_front.sv -----
// Front end: holds the open UTF-8 sequence and turns each byte into at most one work item.
// Depends on udc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module udc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  udc_pkg::t_byte_item i_item,
    output logic               o_work_valid,
    output udc_pkg::t_work     o_work
);
    import udc_pkg::*;

    logic [1:0]  r_pend_count, n_pend_count;
    logic [2:0]  r_exp_len, n_exp_len;
    logic [20:0] r_partial, n_partial;

    logic [7:0]  b;
    logic [20:0] ext_value;
    logic        do_lead;
    logic        bad_value;
    logic [2:0]  rejects;
    logic        point_ok;
    logic [20:0] point_raw;
    logic [20:0] min_value;
    t_classed    classed;

    always_comb begin
        b            = i_item.text_byte;
        ext_value    = {r_partial[14:0], b[5:0]};
        n_pend_count = r_pend_count;
        n_exp_len    = r_exp_len;
        n_partial    = r_partial;
        do_lead      = 1'b0;
        rejects      = 3'd0;
        point_ok     = 1'b0;
        point_raw    = 21'd0;
        bad_value    = 1'b0;
        unique case (r_exp_len)
            3'd2:    min_value = MIN_LEN2;
            3'd3:    min_value = MIN_LEN3;
            default: min_value = MIN_LEN4;
        endcase

        if (r_pend_count == 2'd0) begin
            do_lead = 1'b1;
        end else if (b[7:6] != 2'b10) begin
            // Broken sequence: reject what is held, then read this byte as a new lead.
            rejects      = {1'b0, r_pend_count};
            n_pend_count = 2'd0;
            n_exp_len    = 3'd0;
            n_partial    = 21'd0;
            do_lead      = 1'b1;
        end else if (({1'b0, r_pend_count} + 3'd1) < r_exp_len) begin
            n_pend_count = r_pend_count + 2'd1;
            n_partial    = ext_value;
        end else begin
            bad_value = (ext_value < min_value) || (ext_value > MAX_CODE_POINT) ||
                        (ext_value >= SURROGATE_LO && ext_value <= SURROGATE_HI);
            if (bad_value) begin
                rejects = {1'b0, r_pend_count} + 3'd1;
            end else begin
                point_ok  = 1'b1;
                point_raw = ext_value;
            end
            n_pend_count = 2'd0;
            n_exp_len    = 3'd0;
            n_partial    = 21'd0;
        end

        if (do_lead) begin
            if (b[7] == 1'b0) begin
                point_ok  = 1'b1;
                point_raw = {14'd0, b[6:0]};
            end else if (b[7:5] == 3'b110) begin
                n_pend_count = 2'd1;
                n_exp_len    = 3'd2;
                n_partial    = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                n_pend_count = 2'd1;
                n_exp_len    = 3'd3;
                n_partial    = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                n_pend_count = 2'd1;
                n_exp_len    = 3'd4;
                n_partial    = {18'd0, b[2:0]};
            end else begin
                rejects = rejects + 3'd1;
            end
        end

        // At the end of the text every byte still held is rejected.
        if (i_item.end_of_text && n_pend_count != 2'd0) begin
            rejects      = rejects + {1'b0, n_pend_count};
            n_pend_count = 2'd0;
            n_exp_len    = 3'd0;
            n_partial    = 21'd0;
        end

        classed             = classify(point_raw);
        o_work.reject_count = rejects;
        o_work.point_ok     = point_ok;
        o_work.point_value  = classed.value;
        o_work.point_class  = classed.cls;
        o_work_valid        = i_accept && (point_ok || rejects != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_count <= 2'd0;
            r_exp_len    <= 3'd0;
            r_partial    <= 21'd0;
        end else if (i_accept) begin
            r_pend_count <= n_pend_count;
            r_exp_len    <= n_exp_len;
            r_partial    <= n_partial;
        end
    end

    `UDC_ASSERT(a_open_len, i_clk, i_rst_n, (r_pend_count == 2'd0) || ({1'b0, r_pend_count} < r_exp_len))
    `UDC_ASSERT(a_no_empty_len, i_clk, i_rst_n, (r_pend_count != 2'd0) || (r_exp_len == 3'd0))
    `UDC_ASSERT(a_work_size, i_clk, i_rst_n, !o_work_valid || ({1'b0, o_work.reject_count} + {3'd0, o_work.point_ok} <= 4'd4))

endmodule

// ----- sv/udc_queue.sv -----
// Short register queue of work items between the front end and the result sequencer.
// Depends on udc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module udc_queue #(
    parameter int Depth = udc_pkg::UDC_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  udc_pkg::t_work i_wr_data,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_empty,
    output udc_pkg::t_work o_head
);
    import udc_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_work          r_slots [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + CntW'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slots[r_wr_ptr] <= i_wr_data;
        end
    end

    `UDC_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_wr && o_full))
    `UDC_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_rd && o_empty))
    `UDC_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, i_wr && !i_rd, !o_empty)

endmodule

// ----- sv/udc_back.sv -----
// Result sequencer: expands the head work item into single results, one per pop.
// Depends on udc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module udc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_have_work,
    input  udc_pkg::t_work   i_work,
    input  logic             i_take,
    output logic             o_retire,
    output udc_pkg::t_result o_result
);
    import udc_pkg::*;

    logic [2:0] r_index, n_index;
    logic [2:0] total;
    logic       in_rejects;
    logic       is_last;

    always_comb begin
        total      = i_work.reject_count + {2'd0, i_work.point_ok};
        in_rejects = (r_index < i_work.reject_count);
        is_last    = ((r_index + 3'd1) == total);

        o_result.decoded_ok  = !in_rejects;
        o_result.code_value  = in_rejects ? 21'd0 : i_work.point_value;
        o_result.char_class  = in_rejects ? CLASS_OTHER : i_work.point_class;
        o_result.last_of_run = is_last;

        o_retire = i_take && is_last;
        n_index  = r_index;
        if (o_retire) begin
            n_index = 3'd0;
        end else if (i_take) begin
            n_index = r_index + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= 3'd0;
        end else begin
            r_index <= n_index;
        end
    end

    `UDC_ASSERT(a_index_in_item, i_clk, i_rst_n, !i_have_work || (r_index < total))
    `UDC_ASSERT(a_idle_index, i_clk, i_rst_n, i_have_work || (r_index == 3'd0))

endmodule

// ----- sv/utf8_decode_classify_unit.sv -----
// Strict UTF-8 decoder with character classing, top level.
// Depends on udc_pkg, udc_front, udc_queue, udc_back and assert_macros.svh.
//
// Input side: one text byte per request, pushed with push while full is low.
// A byte may arrive every cycle. Set end_of_text on the last byte of a text;
// any sequence still open is then rejected with one result per held byte.
// Result side: while empty is low the oldest result sits on o_result; pop
// takes it. One byte gives zero to four results (zero when it only opens or
// extends a sequence); last_of_run marks the final result of its byte.
// The results of a byte are registered in the work queue when the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result;
// the sequencer delivers one result per cycle, so a rejection burst of up to
// four results is absorbed by the work queue of QueueDepth items.
// When the receiver stalls the queue fills and full rises; no byte or result
// is lost. Reset (synchronous) closes any open sequence and empties the queue.
module utf8_decode_classify_unit #(
    parameter int QueueDepth = udc_pkg::UDC_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  udc_pkg::t_byte_item i_byte_item,
    output logic                empty,
    input  logic                pop,
    output udc_pkg::t_result    o_result
);
    import udc_pkg::*;

    logic  accept;
    logic  work_valid;
    t_work work;
    t_work head;
    logic  q_empty;
    logic  retire;

    assign accept = push && !full;
    assign empty  = q_empty;

    udc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_byte_item),
        .o_work_valid (work_valid),
        .o_work       (work)
    );

    udc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (work_valid),
        .i_wr_data (work),
        .i_rd      (retire),
        .o_full    (full),
        .o_empty   (q_empty),
        .o_head    (head)
    );

    udc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_have_work (!q_empty),
        .i_work      (head),
        .i_take      (pop && !q_empty),
        .o_retire    (retire),
        .o_result    (o_result)
    );

endmodule
